### rtl/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg: shared types and constants of the markup escape parser
// Character codes, parse modes, style and item layouts used across the block.
// ----------------------------------------------------------------------------
package mep_pkg;

  localparam int unsigned CharWidth = 16;

  typedef logic [CharWidth-1:0] char_t;

  // characters that the parser recognizes
  localparam char_t CH_BSLASH = 16'd92;
  localparam char_t CH_ZERO   = 16'd48;
  localparam char_t CH_NL     = 16'd10;
  localparam char_t CH_A      = 16'd97;   // a
  localparam char_t CH_V      = 16'd118;  // v
  localparam char_t CH_S      = 16'd115;  // s
  localparam char_t CH_N      = 16'd110;  // n
  localparam char_t CH_P      = 16'd112;  // p
  localparam char_t CH_L      = 16'd108;  // l
  localparam char_t CH_X      = 16'd120;  // x
  localparam char_t CH_I      = 16'd105;  // i
  localparam char_t CH_B      = 16'd98;   // b
  localparam char_t CH_BU     = 16'd66;   // B
  localparam char_t CH_C      = 16'd99;   // c
  localparam char_t CH_R      = 16'd114;  // r

  // alignment codes
  localparam logic [1:0] ALIGN_LEFT   = 2'd0;
  localparam logic [1:0] ALIGN_CENTRE = 2'd1;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_DIG1,
    MODE_DIG2,
    MODE_DIG3,
    MODE_SKIP,
    MODE_SKIPESC
  } mode_e;

  typedef struct packed {
    logic       bold;
    logic       italic;
    logic       large_on;
    logic [1:0] align;
  } style_t;

  typedef struct packed {
    mode_e  mode;
    char_t  code_acc;
    style_t style;
  } parse_state_t;

  typedef struct packed {
    char_t in_char;
  } in_item_t;

  typedef struct packed {
    char_t      out_char;
    logic       bold;
    logic       italic;
    logic       large_font;
    logic [1:0] justify;
    logic       red_mark;
  } out_item_t;

endpackage

### rtl/mep_stream_if.sv
// ----------------------------------------------------------------------------
// mep_stream_if: valid/ready stream channel
// Carries one payload per transaction; source drives valid and payload.
// ----------------------------------------------------------------------------
interface mep_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

### rtl/mep_step.sv
// ----------------------------------------------------------------------------
// mep_step: one parse step
// Next parse state and optional styled result for one character.
// ----------------------------------------------------------------------------
module mep_step (
  input  mep_pkg::parse_state_t state_i,
  input  mep_pkg::char_t        char_i,
  output mep_pkg::parse_state_t state_o,
  output logic                  emit_o,
  output mep_pkg::out_item_t    item_o
);
  import mep_pkg::*;

  char_t acc_next;
  char_t res_char;
  logic  res_red;

  // acc * 10 + c - '0', wrapped to 16 bits
  assign acc_next = (state_i.code_acc << 3) + (state_i.code_acc << 1) + char_i - CH_ZERO;

  always_comb begin
    state_o  = state_i;
    emit_o   = 1'b0;
    res_char = char_i;
    res_red  = 1'b0;
    unique case (state_i.mode)
      MODE_ESC: begin
        state_o.mode = MODE_TEXT;
        unique case (char_i)
          CH_BSLASH: begin
            emit_o   = 1'b1;
            res_char = CH_BSLASH;
          end
          CH_A: begin
            state_o.code_acc = '0;
            state_o.mode     = MODE_DIG1;
          end
          CH_V: state_o.mode = MODE_SKIP;
          CH_S, CH_N: state_o.style.large_on = 1'b0;
          CH_P: begin
            state_o.style = '0;
            emit_o        = 1'b1;
            res_char      = CH_NL;
          end
          CH_L: state_o.style.large_on = ~state_i.style.large_on;
          CH_X: begin
            if (!state_i.style.large_on) begin
              state_o.style.large_on = 1'b1;
            end else begin
              state_o.style = '0;
            end
            emit_o   = 1'b1;
            res_char = CH_NL;
          end
          CH_I: state_o.style.italic = ~state_i.style.italic;
          CH_B, CH_BU: state_o.style.bold = ~state_i.style.bold;
          CH_C: begin
            state_o.style.align = (state_i.style.align == ALIGN_CENTRE) ? ALIGN_LEFT
                                                                       : ALIGN_CENTRE;
          end
          CH_R: begin
            state_o.style.align = (state_i.style.align == ALIGN_RIGHT) ? ALIGN_LEFT
                                                                      : ALIGN_RIGHT;
          end
          default: begin
            // unknown escape letter shown red
            emit_o  = 1'b1;
            res_red = 1'b1;
          end
        endcase
      end
      MODE_DIG1: begin
        state_o.code_acc = acc_next;
        state_o.mode     = MODE_DIG2;
      end
      MODE_DIG2: begin
        state_o.code_acc = acc_next;
        state_o.mode     = MODE_DIG3;
      end
      MODE_DIG3: begin
        state_o.code_acc = acc_next;
        if (acc_next == CH_BSLASH) begin
          state_o.mode = MODE_ESC;
        end else begin
          state_o.mode = MODE_TEXT;
          emit_o       = 1'b1;
          res_char     = acc_next;
        end
      end
      MODE_SKIP: begin
        if (char_i == CH_BSLASH) begin
          state_o.mode = MODE_SKIPESC;
        end
      end
      MODE_SKIPESC: begin
        state_o.mode = (char_i == CH_V) ? MODE_TEXT : MODE_SKIP;
      end
      default: begin
        if (char_i == CH_BSLASH) begin
          state_o.mode = MODE_ESC;
        end else begin
          state_o.mode = MODE_TEXT;
          emit_o       = 1'b1;
        end
      end
    endcase
  end

  // results carry the style as left by this step
  always_comb begin
    item_o.out_char   = res_char;
    item_o.bold       = state_o.style.bold;
    item_o.italic     = state_o.style.italic;
    item_o.large_font = state_o.style.large_on;
    item_o.justify    = state_o.style.align;
    item_o.red_mark   = res_red;
  end

endmodule

### rtl/markup_escape_parser_top.sv
// ----------------------------------------------------------------------------
// markup_escape_parser_top: backslash escape parser for 16-bit text
// Turns a character stream into styled characters, zero or one per input.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while the output keeps taking
// results and gives at most one styled character per input: the character
// sits in an input register, one parse step updates the kept state, and the
// result lands in an output register. The only loop is the parse state, which
// the combinational step closes, so the sustained rate is one character
// per clock while the output side keeps taking results; ready on the input
// is combinational from output ready and the input and output register state.
module markup_escape_parser_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mep_stream_if.sink           in_i,
  mep_stream_if.source         out_o
);
  import mep_pkg::*;

  // input stage
  logic         in_valid_q;
  char_t        in_char_q;

  // kept parse state and style
  parse_state_t state_q;
  parse_state_t state_d;

  // step results
  logic         step_emit;
  out_item_t    step_item;

  // output register
  logic         out_valid_q;
  out_item_t    out_item_q;

  // the held character moves on once the output register can take a result
  logic         advance;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  mep_step u_step (
    .state_i (state_q),
    .char_i  (in_char_q),
    .state_o (state_d),
    .emit_o  (step_emit),
    .item_o  (step_item)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{mode: MODE_TEXT, code_acc: '0, style: '0};
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= step_emit;
      end else if (out_o.ready) begin
        // result taken, nothing new behind it
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_char_q <= in_i.payload.in_char;
    end
    if (advance && step_emit) begin
      out_item_q <= step_item;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule
